>>> hw/rtl/tsq_pkg.sv
// ----------------------------------------------------------------------------
// tsq_pkg
// shared types and constants of the timestamp ordered event queue
// ----------------------------------------------------------------------------
package tsq_pkg;

	localparam int ID_W   = 32;
	localparam int KIND_W = 2;
	localparam int TIME_W = 48;

	localparam int QUEUE_DEPTH_DEF = 16;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_FLUSH  = 1'b1;

	localparam logic [KIND_W-1:0] KIND_ARRIVAL = 2'd0;

	localparam logic ITEM_EVENT  = 1'b0;
	localparam logic ITEM_STATUS = 1'b1;

	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	typedef struct packed {
		logic [TIME_W-1:0] ev_time;
		logic [ID_W-1:0]   ev_id;
		logic [KIND_W-1:0] ev_kind;
	} tsq_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SEARCH_WAIT,
		ST_PLACE,
		ST_RELEASE,
		ST_RELEASE_WAIT,
		ST_STATUS
	} tsq_state_t;

endpackage

>>> hw/rtl/timestamp_ordered_event_queue_core.sv
// ----------------------------------------------------------------------------
// timestamp_ordered_event_queue_core
// time ordered event queue with sorted insertion, release and flush
// ----------------------------------------------------------------------------
// usage:
//   an item (command, event_id, event_kind, event_time) is taken at a rising
//   edge with start high and busy low. busy stays high until the item is done.
//   results leave on item_type/out_id/out_kind/out_time/status/last, each valid
//   for one cycle while strobe is high; the receiver cannot stall them.
//   every item ends with one status item (last high, status flags a full
//   queue on insert). released events come first, oldest first.
// storage:
//   entries sit in a circular buffer with one write and one registered read
//   port. an insert moves each later entry up one place through the read
//   port before it writes the new one, and an arrival insert then releases
//   the entries ahead of it, oldest first; a flush releases every entry and
//   a rejected insert goes straight to its status item.
// reset:
//   arst_n empties the queue at once; no clearing pass, stored entries are
//   only read below the fill count.
// ----------------------------------------------------------------------------
module timestamp_ordered_event_queue_core #(
	parameter int QUEUE_DEPTH = tsq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       command,
	input  logic [tsq_pkg::ID_W-1:0]   event_id,
	input  logic [tsq_pkg::KIND_W-1:0] event_kind,
	input  logic [tsq_pkg::TIME_W-1:0] event_time,
	output logic                       strobe,
	output logic                       item_type,
	output logic [tsq_pkg::ID_W-1:0]   out_id,
	output logic [tsq_pkg::KIND_W-1:0] out_kind,
	output logic [tsq_pkg::TIME_W-1:0] out_time,
	output logic                       status,
	output logic                       last
);
	import tsq_pkg::*;

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [AW:0]   DEPTH_A = (AW + 1)'(QUEUE_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
	localparam logic [AW-1:0] HEAD_MAX = AW'(QUEUE_DEPTH - 1);

	function automatic logic [AW-1:0] phys_addr(input logic [AW-1:0] head,
			input logic [AW-1:0] lg);
		logic [AW:0] sum;
		sum = {1'b0, head} + {1'b0, lg};
		if (sum >= DEPTH_A) begin
			sum = sum - DEPTH_A;
		end
		return sum[AW-1:0];
	endfunction

	tsq_state_t state_q, state_d;

	logic              cmd_q;
	logic [ID_W-1:0]   id_q;
	logic [KIND_W-1:0] kind_q;
	logic [TIME_W-1:0] time_q;
	logic              reject_q;
	logic [AW-1:0]     head_q;
	logic [CW-1:0]     occ_q;
	logic [CW-1:0]     pos_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     pos_dec;

	tsq_entry_t        mem_q [QUEUE_DEPTH];
	tsq_entry_t        rd_q;
	tsq_entry_t        wdata;
	logic              mem_we;
	logic              rd_en;
	logic [AW-1:0]     waddr;
	logic [AW-1:0]     raddr;
	logic              emit_evt;
	logic              emit_stat;
	logic              shift_hit;

	logic              strobe_q;
	logic              item_type_q;
	logic [ID_W-1:0]   out_id_q;
	logic [KIND_W-1:0] out_kind_q;
	logic [TIME_W-1:0] out_time_q;
	logic              status_q;
	logic              last_q;

	assign pos_dec   = pos_q - CW'(1);
	assign shift_hit = rd_q.ev_time > time_q;
	assign busy      = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		rd_en     = 1'b0;
		waddr     = phys_addr(head_q, pos_q[AW-1:0]);
		raddr     = head_q;
		wdata     = '{ev_time: time_q, ev_id: id_q, ev_kind: kind_q};
		emit_evt  = 1'b0;
		emit_stat = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (command == CMD_FLUSH) begin
						state_d = ST_RELEASE;
					end else if (occ_q == DEPTH_C) begin
						state_d = ST_STATUS;
					end else begin
						state_d = ST_SEARCH;
					end
				end
			end
			ST_SEARCH: begin
				if (pos_q == '0) begin
					state_d = ST_PLACE;
				end else begin
					rd_en   = 1'b1;
					raddr   = phys_addr(head_q, pos_dec[AW-1:0]);
					state_d = ST_SEARCH_WAIT;
				end
			end
			ST_SEARCH_WAIT: begin
				if (shift_hit) begin
					mem_we  = 1'b1;
					wdata   = rd_q;
					state_d = ST_SEARCH;
				end else begin
					state_d = ST_PLACE;
				end
			end
			ST_PLACE: begin
				mem_we = 1'b1;
				if (kind_q == KIND_ARRIVAL && pos_q != '0) begin
					state_d = ST_RELEASE;
				end else begin
					state_d = ST_STATUS;
				end
			end
			ST_RELEASE: begin
				if (cnt_q == '0) begin
					state_d = ST_STATUS;
				end else begin
					rd_en   = 1'b1;
					state_d = ST_RELEASE_WAIT;
				end
			end
			ST_RELEASE_WAIT: begin
				emit_evt = 1'b1;
				state_d  = ST_RELEASE;
			end
			ST_STATUS: begin
				emit_stat = 1'b1;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reject_q <= 1'b0;
			head_q   <= '0;
			occ_q    <= '0;
			pos_q    <= '0;
			cnt_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						reject_q <= (command == CMD_INSERT) && (occ_q == DEPTH_C);
						pos_q    <= occ_q;
						cnt_q    <= occ_q;
					end
				end
				ST_SEARCH_WAIT: begin
					if (shift_hit) begin
						pos_q <= pos_dec;
					end
				end
				ST_PLACE: begin
					occ_q <= occ_q + CW'(1);
					cnt_q <= pos_q;
				end
				ST_RELEASE_WAIT: begin
					head_q <= (head_q == HEAD_MAX) ? '0 : head_q + AW'(1);
					occ_q  <= occ_q - CW'(1);
					cnt_q  <= cnt_q - CW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q  <= command;
			id_q   <= event_id;
			kind_q <= event_kind;
			time_q <= event_time;
		end
	end

	// entry memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem_q[raddr];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit_evt || emit_stat;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_evt) begin
			item_type_q <= ITEM_EVENT;
			out_id_q    <= rd_q.ev_id;
			out_kind_q  <= rd_q.ev_kind;
			out_time_q  <= rd_q.ev_time;
			status_q    <= STATUS_OK;
			last_q      <= 1'b0;
		end else if (emit_stat) begin
			item_type_q <= ITEM_STATUS;
			out_id_q    <= '0;
			out_kind_q  <= '0;
			out_time_q  <= '0;
			status_q    <= (reject_q && cmd_q == CMD_INSERT) ? STATUS_REJECT : STATUS_OK;
			last_q      <= 1'b1;
		end
	end

	assign strobe    = strobe_q;
	assign item_type = item_type_q;
	assign out_id    = out_id_q;
	assign out_kind  = out_kind_q;
	assign out_time  = out_time_q;
	assign status    = status_q;
	assign last      = last_q;

endmodule

>>> hw/rtl/tsq_checker.sv
// ----------------------------------------------------------------------------
// tsq_checker
// port level checks of the timestamp ordered event queue
// ----------------------------------------------------------------------------
module tsq_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       strobe,
	input logic                       item_type,
	input logic                       status,
	input logic                       last
);
	import tsq_pkg::*;

	// an accepted item always has the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	// the status item closes the run and the block is free again
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !busy && item_type == ITEM_STATUS)
		else $error("closing item while busy or of wrong type");

	// released events come while the item is still in progress
	a_release_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy && item_type == ITEM_EVENT && status == STATUS_OK)
		else $error("released event outside of a run");

	// no result directly follows the closing item
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("result right after closing item");

endmodule

bind timestamp_ordered_event_queue_core tsq_checker u_tsq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.strobe    (strobe),
	.item_type (item_type),
	.status    (status),
	.last      (last)
);
